// ===== sv/iws_pkg.sv =====
// ----------------------------------------------------------------------------
// iws_pkg: shared types and codes for the interval workout sequencer
// Command and phase codes, register indexes, channel word types, and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package iws_pkg;

   localparam int unsigned ADDR_W = 5;
   localparam int unsigned CNT_W  = 17;
   localparam int unsigned PROD_W = 41;

   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_ARM   = 3'd1;
   localparam logic [2:0] MODE_REARM = 3'd2;
   localparam logic [2:0] MODE_START = 3'd3;
   localparam logic [2:0] MODE_STOP  = 3'd4;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_ARMED = 3'd1;
   localparam logic [2:0] PH_RUN   = 3'd2;
   localparam logic [2:0] PH_PREST = 3'd3;
   localparam logic [2:0] PH_SREST = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;

   localparam logic [2:0] REG_PASS_BY_DISTANCE  = 3'd0;
   localparam logic [2:0] REG_PASS_TIME         = 3'd1;
   localparam logic [2:0] REG_PASS_DISTANCE     = 3'd2;
   localparam logic [2:0] REG_EXTRA_SERIES      = 3'd3;
   localparam logic [2:0] REG_PASSES_PER_SERIES = 3'd4;
   localparam logic [2:0] REG_PASS_REST_TIME    = 3'd5;
   localparam logic [2:0] REG_SERIES_REST_TIME  = 3'd6;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] elapsed;
      logic [31:0] odometer;
   } req_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [23:0] pass_time_left;
      logic [23:0] pass_distance_left;
      logic [23:0] rest_time_left;
      logic [7:0]  series_to_go;
      logic [7:0]  passes_to_go;
      logic [31:0] work_time_total;
      logic [31:0] work_distance_total;
   } rsp_type;

   typedef struct packed {
      logic        pass_by_distance;
      logic [23:0] pass_time;
      logic [23:0] pass_distance;
      logic [7:0]  extra_series;
      logic [7:0]  passes_per_series;
      logic [23:0] pass_rest_time;
      logic [23:0] series_rest_time;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic commit;
      logic plan;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic plan_req;
   } sts_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? '1 : sum[31:0];
   endfunction

endpackage

// ===== sv/interval_workout_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// interval_workout_sequencer_top: interval training sequencer
// Takes one command word per item (tick, arm, rearm, start, stop) and returns
// one result word with the phase, countdowns, counters and totals.
//
// Usage:
//   - Request channel req_*: valid/ready, one command word per transfer.
//   - Result channel rsp_*: valid/ready, exactly one result word per command.
//   - APB port: seven settings at byte addresses 0, 4, ... 24, pready tied
//     high; write settings only while no command is in flight.
//   - A command passes through capture, then state update into the result
//     register. A tick that ends the workout adds a step for the planned-total
//     multiply (pass count x pass length, registered).
//   - Result valid is registered and rises as the result register is loaded.
//   - A new command is taken while a result still waits; if the receiver
//     stalls, the next update holds until the result register is free.
//   - Synchronous reset: phase idle, all counters, totals and settings zero.
// ----------------------------------------------------------------------------
module interval_workout_sequencer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  iws_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output iws_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [iws_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   iws_pkg::cfg_type cfg;
   iws_pkg::cmd_type cmd;
   iws_pkg::sts_type sts;

   iws_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   iws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iws_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sv/iws_csr.sv =====
// ----------------------------------------------------------------------------
// iws_csr: configuration register file
// APB-style slave holding the seven workout settings; reads return them.
// ----------------------------------------------------------------------------
module iws_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [iws_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output iws_pkg::cfg_type              cfg
);

   iws_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       reg_idx;

   assign reg_idx = paddr[iws_pkg::ADDR_W-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_idx)
            iws_pkg::REG_PASS_BY_DISTANCE:  cfg_in.pass_by_distance  = pwdata[0];
            iws_pkg::REG_PASS_TIME:         cfg_in.pass_time         = pwdata[23:0];
            iws_pkg::REG_PASS_DISTANCE:     cfg_in.pass_distance     = pwdata[23:0];
            iws_pkg::REG_EXTRA_SERIES:      cfg_in.extra_series      = pwdata[7:0];
            iws_pkg::REG_PASSES_PER_SERIES: cfg_in.passes_per_series = pwdata[7:0];
            iws_pkg::REG_PASS_REST_TIME:    cfg_in.pass_rest_time    = pwdata[23:0];
            iws_pkg::REG_SERIES_REST_TIME:  cfg_in.series_rest_time  = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         iws_pkg::REG_PASS_BY_DISTANCE:  prdata = {31'd0, cfg_ff.pass_by_distance};
         iws_pkg::REG_PASS_TIME:         prdata = {8'd0, cfg_ff.pass_time};
         iws_pkg::REG_PASS_DISTANCE:     prdata = {8'd0, cfg_ff.pass_distance};
         iws_pkg::REG_EXTRA_SERIES:      prdata = {24'd0, cfg_ff.extra_series};
         iws_pkg::REG_PASSES_PER_SERIES: prdata = {24'd0, cfg_ff.passes_per_series};
         iws_pkg::REG_PASS_REST_TIME:    prdata = {8'd0, cfg_ff.pass_rest_time};
         iws_pkg::REG_SERIES_REST_TIME:  prdata = {8'd0, cfg_ff.series_rest_time};
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/iws_ctrl.sv =====
// ----------------------------------------------------------------------------
// iws_ctrl: sequencing controller
// Steps each command word through capture, update and the optional planned
// total, and owns the result valid flag.
// ----------------------------------------------------------------------------
module iws_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  iws_pkg::sts_type  sts,
   output iws_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {ST_WAIT, ST_UPD, ST_PLAN} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_WAIT);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_WAIT: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               if (sts.plan_req) begin
                  state_in = ST_PLAN;
               end else begin
                  cmd.load_out = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_WAIT;
               end
            end
         end
         ST_PLAN: begin
            if (out_free) begin
               cmd.plan     = 1'b1;
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/iws_dp.sv =====
// ----------------------------------------------------------------------------
// iws_dp: sequencer datapath
// Holds the workout state, computes the effect of one command word, the
// planned total product, and the result register.
// ----------------------------------------------------------------------------
module iws_dp (
   input  logic              clock,
   input  logic              reset,
   input  iws_pkg::cfg_type  cfg,
   input  iws_pkg::cmd_type  cmd,
   input  iws_pkg::req_type  req_data,
   output iws_pkg::sts_type  sts,
   output iws_pkg::rsp_type  rsp_data
);

   iws_pkg::rsp_type             st_ff, st_in, step, out_ff;
   logic [31:0]                  lodo_ff, lodo_in, step_lodo;
   logic [2:0]                   mode_ff;
   logic [15:0]                  elapsed_ff;
   logic [31:0]                  odo_ff;
   logic [31:0]                  delta_ff, delta_in;
   logic [iws_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [iws_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [23:0]                  base;
   logic [31:0]                  plan_total;
   logic [8:0]                   series_count;
   logic                         plan_req;

   assign delta_in     = (req_data.odometer > lodo_ff) ? (req_data.odometer - lodo_ff) : '0;
   assign series_count = {1'b0, cfg.extra_series} + 9'd1;
   assign cnt_in       = iws_pkg::CNT_W'(cfg.passes_per_series)
                         * iws_pkg::CNT_W'(series_count);
   assign base         = cfg.pass_by_distance ? cfg.pass_distance : cfg.pass_time;
   assign prod_in      = iws_pkg::PROD_W'(cnt_ff) * iws_pkg::PROD_W'(base);
   assign plan_total   = (|prod_ff[iws_pkg::PROD_W-1:32]) ? '1 : prod_ff[31:0];
   assign sts.plan_req = plan_req;
   assign rsp_data     = out_ff;

   always_comb begin
      logic [23:0] el24;
      logic [23:0] used;
      logic [7:0]  passes_dec;
      logic        fin;
      logic        run_go;
      step       = st_ff;
      step_lodo  = lodo_ff;
      plan_req   = 1'b0;
      run_go     = 1'b0;
      fin        = 1'b0;
      used       = '0;
      el24       = {8'd0, elapsed_ff};
      passes_dec = (st_ff.passes_to_go != 8'd0) ? (st_ff.passes_to_go - 8'd1) : 8'd0;
      case (mode_ff)
         iws_pkg::MODE_TICK: begin
            if (!(st_ff.phase inside {iws_pkg::PH_IDLE, iws_pkg::PH_DONE})) begin
               step_lodo = odo_ff;
               if (st_ff.phase == iws_pkg::PH_RUN) begin
                  if (!cfg.pass_by_distance) begin
                     fin  = (el24 >= st_ff.pass_time_left);
                     used = fin ? st_ff.pass_time_left : el24;
                     step.pass_time_left  = st_ff.pass_time_left - used;
                     step.work_time_total = iws_pkg::sat_add32(st_ff.work_time_total,
                                                               {8'd0, used});
                     step.work_distance_total =
                        iws_pkg::sat_add32(st_ff.work_distance_total, delta_ff);
                  end else begin
                     fin  = (delta_ff >= {8'd0, st_ff.pass_distance_left});
                     used = fin ? st_ff.pass_distance_left : delta_ff[23:0];
                     step.pass_distance_left = st_ff.pass_distance_left - used;
                     step.work_time_total = iws_pkg::sat_add32(st_ff.work_time_total,
                                                               {16'd0, elapsed_ff});
                     step.work_distance_total =
                        iws_pkg::sat_add32(st_ff.work_distance_total, {8'd0, used});
                  end
                  if (fin) begin
                     step.passes_to_go = passes_dec;
                     if (passes_dec != 8'd0) begin
                        if (cfg.pass_rest_time != 24'd0) begin
                           step.phase          = iws_pkg::PH_PREST;
                           step.rest_time_left = cfg.pass_rest_time;
                        end else begin
                           run_go = 1'b1;
                        end
                     end else if (st_ff.series_to_go != 8'd0) begin
                        step.series_to_go = st_ff.series_to_go - 8'd1;
                        step.passes_to_go = cfg.passes_per_series;
                        if (cfg.series_rest_time != 24'd0) begin
                           step.phase          = iws_pkg::PH_SREST;
                           step.rest_time_left = cfg.series_rest_time;
                        end else begin
                           run_go = 1'b1;
                        end
                     end else begin
                        step.phase        = iws_pkg::PH_DONE;
                        step.passes_to_go = 8'd0;
                        step.series_to_go = 8'd0;
                        plan_req          = 1'b1;
                     end
                  end
               end else if (st_ff.phase inside {iws_pkg::PH_PREST, iws_pkg::PH_SREST}) begin
                  if (st_ff.rest_time_left > el24) begin
                     step.rest_time_left = st_ff.rest_time_left - el24;
                  end else begin
                     step.rest_time_left = '0;
                     run_go              = 1'b1;
                  end
               end
            end
         end
         iws_pkg::MODE_ARM, iws_pkg::MODE_REARM: begin
            step.work_time_total     = '0;
            step.work_distance_total = '0;
            step.series_to_go        = cfg.extra_series;
            step.passes_to_go        = cfg.passes_per_series;
            step.phase               = iws_pkg::PH_ARMED;
            if (mode_ff == iws_pkg::MODE_REARM) step_lodo = odo_ff;
         end
         iws_pkg::MODE_START: begin
            if (st_ff.phase == iws_pkg::PH_ARMED) begin
               step_lodo = odo_ff;
               run_go    = 1'b1;
            end
         end
         iws_pkg::MODE_STOP: begin
            step.phase              = iws_pkg::PH_IDLE;
            step.pass_time_left     = '0;
            step.pass_distance_left = '0;
            step.rest_time_left     = '0;
         end
         default: ;
      endcase
      if (run_go) begin
         step.phase = iws_pkg::PH_RUN;
         if (cfg.pass_by_distance) begin
            step.pass_distance_left = cfg.pass_distance;
         end else begin
            step.pass_time_left = cfg.pass_time;
         end
      end
   end

   always_comb begin
      st_in   = st_ff;
      lodo_in = lodo_ff;
      if (cmd.commit) begin
         st_in   = step;
         lodo_in = step_lodo;
      end else if (cmd.plan) begin
         if (cfg.pass_by_distance) begin
            st_in.work_distance_total = plan_total;
         end else begin
            st_in.work_time_total = plan_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= '0;
         lodo_ff <= '0;
      end else begin
         st_ff   <= st_in;
         lodo_ff <= lodo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff    <= req_data.mode;
         elapsed_ff <= req_data.elapsed;
         odo_ff     <= req_data.odometer;
         delta_ff   <= delta_in;
         cnt_ff     <= cnt_in;
      end
      if (cmd.commit) prod_ff <= prod_in;
      if (cmd.load_out) out_ff <= st_in;
   end

endmodule

// ===== sv/iws_chk.sv =====
// ----------------------------------------------------------------------------
// iws_chk: port-level checks for the interval workout sequencer
// Watches the top-level ports for handshake and phase consistency.
// ----------------------------------------------------------------------------
module iws_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input iws_pkg::rsp_type              rsp_data
);

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on back-to-back cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_done_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == iws_pkg::PH_DONE
      |-> rsp_data.series_to_go == 8'd0 && rsp_data.passes_to_go == 8'd0)
      else $error("done with passes or series left");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == iws_pkg::PH_IDLE
      |-> rsp_data.pass_time_left == 24'd0 && rsp_data.pass_distance_left == 24'd0
          && rsp_data.rest_time_left == 24'd0)
      else $error("idle with live countdown");

   a_armed_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == iws_pkg::PH_ARMED
      |-> rsp_data.work_time_total == 32'd0 && rsp_data.work_distance_total == 32'd0)
      else $error("armed with nonzero totals");

endmodule

bind interval_workout_sequencer_top iws_chk u_iws_chk (.*);
